>>> rtl/vertex_rotate_project_top_defines.svh
// Assertion macros shared by the vertex transform RTL.
// Included by the modules that carry checks; expects clk and arst_n in scope.
`ifndef VERTEX_ROTATE_PROJECT_TOP_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define VRP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, checked out of reset
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define VRP_ASSERT_IMP(lbl, ante, cons, msg)
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> rtl/vrp_pkg.sv
// Shared types, constants and ROM generator for the vertex transform pipeline.
// No dependencies; every other RTL file refers to it by scoped names.
package vrp_pkg;

	// field widths
	localparam int VTX_W      = 16;
	localparam int ANGLE_W    = 9;
	localparam int SCREEN_W   = 16;
	localparam int SCALE_W    = 10;
	localparam int OFFSET_W   = 12;
	localparam int TRIG_W     = 16;
	// rotated coordinates stay below 2^28 in magnitude
	localparam int COORD_W    = 30;
	localparam int PROD_W     = COORD_W + TRIG_W;
	localparam int ROT_FRAC   = 14;

	// configuration port
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 2;
	localparam logic [REG_IDX_W-1:0] REG_SCALE_FACTOR = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HALF_WIDTH   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_HALF_HEIGHT  = 2'd2;

	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 10'd150;
	localparam logic [OFFSET_W-1:0] HALF_W_RESET = 12'd400;
	localparam logic [OFFSET_W-1:0] HALF_H_RESET = 12'd300;

	// saturation bounds of a pixel coordinate
	localparam logic signed [SCREEN_W-1:0] PIX_MAX = 16'sh7FFF;
	localparam logic signed [SCREEN_W-1:0] PIX_MIN = 16'sh8000;

	// angles in Q30 radians
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;

	// Taylor divisors (2n)(2n+1) for n = 1..10
	localparam longint unsigned TAYLOR_DIV [10] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
		64'd156, 64'd210, 64'd272, 64'd342, 64'd420
	};

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
	} trig_t;

	typedef struct packed {
		logic [SCALE_W-1:0]  scale_factor;
		logic [OFFSET_W-1:0] half_width;
		logic [OFFSET_W-1:0] half_height;
	} cfg_t;

	// sine in Q1.14 of an angle in [0, 2*pi) given in Q30; used at elaboration only
	function automatic logic signed [TRIG_W-1:0] sin_q14(input longint a_in);
		longint a;
		logic neg;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned r;
		int n;
		a = a_in;
		neg = 1'b0;
		if (a >= PI_Q30) begin
			a = a - PI_Q30;
			neg = 1'b1;
		end
		if (a > HALF_PI_Q30)
			a = PI_Q30 - a;
		if (a < 0)
			a = 0;
		x = unsigned'(a);
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (n = 1; n <= 10; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
			if ((n & 1) == 1)
				sum = sum - term;
			else
				sum = sum + term;
		end
		r = (sum + 64'd32768) >> 16;
		if (r > 64'd16384)
			r = 64'd16384;
		return neg ? $signed(-TRIG_W'(r)) : $signed(TRIG_W'(r));
	endfunction

	// round half up from Q14 products back to coordinate scale
	function automatic coord_t rot_round(input logic signed [PROD_W:0] s);
		logic signed [PROD_W:0] b;
		b = s + (PROD_W + 1)'(1 << (ROT_FRAC - 1));
		return signed'(b[ROT_FRAC +: COORD_W]);
	endfunction

endpackage

>>> rtl/vertex_rotate_project_top.sv
// vertex_rotate_project_top: scale, X/Y/Z Euler rotation and orthographic
// projection of one Q3.13 vertex per word to a 16-bit pixel position.
// Depends on vrp_pkg, vrp_cfg_regs, vrp_sincos_rom, vrp_pixel_out.
// Input channel vtx: vtx_valid/vtx_stall with vertex_x/y/z and three angle
// codes (0..359 degrees, larger codes wrap). Output channel pix:
// pix_valid/pix_stall with screen_x/screen_y. A word moves at a clock edge
// where valid is high and stall is low.
// Eight register stages: ROM read and scale, X products, X sums, Y products,
// Y sum, Z products, Z sums, pixel rounding. One word per cycle is sustained
// while pix_stall is low. Every stage loads when empty or when the next
// stage loads, so bubbles close up; a stall at pix holds the output word and
// fills the stages behind it before vtx_stall rises. Nothing is dropped or
// repeated.
// Reset (arst_n low) empties the pipeline and sets scale_factor 150,
// half_width 400, half_height 300. Registers sit at 0x0, 0x4, 0x8 on the
// APB-style port and are to be written only while the pipeline is empty.
`include "vertex_rotate_project_top_defines.svh"

module vertex_rotate_project_top #(
	parameter int ANGLE_STEPS     = 360,
	parameter int COORD_FRAC_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [vrp_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [vrp_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready,
	input  logic                                vtx_valid,
	output logic                                vtx_stall,
	input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_x,
	input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_y,
	input  logic signed [vrp_pkg::VTX_W-1:0]    vertex_z,
	input  logic [vrp_pkg::ANGLE_W-1:0]         angle_x_deg,
	input  logic [vrp_pkg::ANGLE_W-1:0]         angle_y_deg,
	input  logic [vrp_pkg::ANGLE_W-1:0]         angle_z_deg,
	output logic                                pix_valid,
	input  logic                                pix_stall,
	output logic signed [vrp_pkg::SCREEN_W-1:0] screen_x,
	output logic signed [vrp_pkg::SCREEN_W-1:0] screen_y
);

	vrp_pkg::cfg_t   cfg;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	// stage 1: scaled vertex, trig words
	vrp_pkg::coord_t x_s1, y_s1, z_s1;
	vrp_pkg::trig_t  tx_s1, ty_s1, tz_s1;
	// stage 2: X products
	vrp_pkg::prod_t  cxy_s2, sxz_s2, sxy_s2, cxz_s2;
	vrp_pkg::coord_t x_s2;
	vrp_pkg::trig_t  ty_s2, tz_s2;
	// stage 3: X rotated
	vrp_pkg::coord_t x_s3, y_s3, z_s3;
	vrp_pkg::trig_t  ty_s3, tz_s3;
	// stage 4: Y products
	vrp_pkg::prod_t  cyx_s4, syz_s4;
	vrp_pkg::coord_t y_s4;
	vrp_pkg::trig_t  tz_s4;
	// stage 5: Y rotated
	vrp_pkg::coord_t x_s5, y_s5;
	vrp_pkg::trig_t  tz_s5;
	// stage 6: Z products
	vrp_pkg::prod_t  czx_s6, szy_s6, szx_s6, czy_s6;
	// stage 7: Z rotated
	vrp_pkg::coord_t x_s7, y_s7;

	logic signed [vrp_pkg::SCALE_W:0] scale_s;

	vrp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// back-pressure chain, a stage loads when empty or when its successor loads
	assign en_s7 = !v_s7 || en_s8;
	assign en_s6 = !v_s6 || en_s7;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign vtx_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= vtx_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// stage 1: trig lookups
	vrp_sincos_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_x (
		.clk(clk), .en(en_s1), .angle(angle_x_deg), .trig_s1(tx_s1)
	);
	vrp_sincos_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_y (
		.clk(clk), .en(en_s1), .angle(angle_y_deg), .trig_s1(ty_s1)
	);
	vrp_sincos_rom #(.ANGLE_STEPS(ANGLE_STEPS)) u_rom_z (
		.clk(clk), .en(en_s1), .angle(angle_z_deg), .trig_s1(tz_s1)
	);

	// stage 1: uniform scale
	assign scale_s = signed'({1'b0, cfg.scale_factor});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1 <= vertex_x * scale_s;
			y_s1 <= vertex_y * scale_s;
			z_s1 <= vertex_z * scale_s;
		end
	end

	// stage 2: products for rotation about X
	always_ff @(posedge clk) begin
		if (en_s2) begin
			cxy_s2 <= tx_s1.cos_v * y_s1;
			sxz_s2 <= tx_s1.sin_v * z_s1;
			sxy_s2 <= tx_s1.sin_v * y_s1;
			cxz_s2 <= tx_s1.cos_v * z_s1;
			x_s2   <= x_s1;
			ty_s2  <= ty_s1;
			tz_s2  <= tz_s1;
		end
	end

	// stage 3: y' = cx*y - sx*z, z' = sx*y + cx*z
	always_ff @(posedge clk) begin
		if (en_s3) begin
			y_s3  <= vrp_pkg::rot_round((vrp_pkg::PROD_W + 1)'(cxy_s2)
				- (vrp_pkg::PROD_W + 1)'(sxz_s2));
			z_s3  <= vrp_pkg::rot_round((vrp_pkg::PROD_W + 1)'(sxy_s2)
				+ (vrp_pkg::PROD_W + 1)'(cxz_s2));
			x_s3  <= x_s2;
			ty_s3 <= ty_s2;
			tz_s3 <= tz_s2;
		end
	end

	// stage 4: products for rotation about Y (z is not needed afterwards)
	always_ff @(posedge clk) begin
		if (en_s4) begin
			cyx_s4 <= ty_s3.cos_v * x_s3;
			syz_s4 <= ty_s3.sin_v * z_s3;
			y_s4   <= y_s3;
			tz_s4  <= tz_s3;
		end
	end

	// stage 5: x' = cy*x + sy*z
	always_ff @(posedge clk) begin
		if (en_s5) begin
			x_s5  <= vrp_pkg::rot_round((vrp_pkg::PROD_W + 1)'(cyx_s4)
				+ (vrp_pkg::PROD_W + 1)'(syz_s4));
			y_s5  <= y_s4;
			tz_s5 <= tz_s4;
		end
	end

	// stage 6: products for rotation about Z
	always_ff @(posedge clk) begin
		if (en_s6) begin
			czx_s6 <= tz_s5.cos_v * x_s5;
			szy_s6 <= tz_s5.sin_v * y_s5;
			szx_s6 <= tz_s5.sin_v * x_s5;
			czy_s6 <= tz_s5.cos_v * y_s5;
		end
	end

	// stage 7: x' = cz*x - sz*y, y' = sz*x + cz*y
	always_ff @(posedge clk) begin
		if (en_s7) begin
			x_s7 <= vrp_pkg::rot_round((vrp_pkg::PROD_W + 1)'(czx_s6)
				- (vrp_pkg::PROD_W + 1)'(szy_s6));
			y_s7 <= vrp_pkg::rot_round((vrp_pkg::PROD_W + 1)'(szx_s6)
				+ (vrp_pkg::PROD_W + 1)'(czy_s6));
		end
	end

	// stage 8: projection to pixel, output register
	vrp_pixel_out #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_pix (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s7  (v_s7),
		.x_s7      (x_s7),
		.y_s7      (y_s7),
		.cfg       (cfg),
		.en_s8     (en_s8),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.screen_x  (screen_x),
		.screen_y  (screen_y)
	);

	`VRP_ASSERT_IMP(a_stall_needs_full, vtx_stall, v_s1 && v_s7 && pix_valid, "input stalled with a free slot")
	`VRP_ASSERT_NEXT(a_s7_holds, v_s7 && !en_s8, v_s7 && $stable(x_s7) && $stable(y_s7), "stage 7 lost its word under stall")

endmodule

>>> rtl/vrp_cfg_regs.sv
// Configuration register bank behind the APB-style port.
// Depends on vrp_pkg and the assertion macro header.
`include "vertex_rotate_project_top_defines.svh"

module vrp_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [vrp_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [vrp_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [vrp_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	output vrp_pkg::cfg_t                    cfg
);

	vrp_pkg::cfg_t                    cfg_q;
	logic                             wr_en;
	logic [vrp_pkg::REG_IDX_W-1:0]    reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[vrp_pkg::CFG_ADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.scale_factor <= vrp_pkg::SCALE_RESET;
			cfg_q.half_width   <= vrp_pkg::HALF_W_RESET;
			cfg_q.half_height  <= vrp_pkg::HALF_H_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				vrp_pkg::REG_SCALE_FACTOR: cfg_q.scale_factor <= pwdata[vrp_pkg::SCALE_W-1:0];
				vrp_pkg::REG_HALF_WIDTH:   cfg_q.half_width   <= pwdata[vrp_pkg::OFFSET_W-1:0];
				vrp_pkg::REG_HALF_HEIGHT:  cfg_q.half_height  <= pwdata[vrp_pkg::OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux, unmapped addresses read zero
	always_comb begin
		unique case (reg_idx)
			vrp_pkg::REG_SCALE_FACTOR: prdata = vrp_pkg::CFG_DATA_W'(cfg_q.scale_factor);
			vrp_pkg::REG_HALF_WIDTH:   prdata = vrp_pkg::CFG_DATA_W'(cfg_q.half_width);
			vrp_pkg::REG_HALF_HEIGHT:  prdata = vrp_pkg::CFG_DATA_W'(cfg_q.half_height);
			default:                   prdata = '0;
		endcase
	end

	`VRP_ASSERT_NEXT(a_scale_write, wr_en && (reg_idx == vrp_pkg::REG_SCALE_FACTOR), cfg_q.scale_factor == $past(pwdata[vrp_pkg::SCALE_W-1:0]), "scale_factor write not taken")

endmodule

>>> rtl/vrp_sincos_rom.sv
// Sine/cosine ROM in Q1.14, one entry per 9-bit angle code, registered read.
// Contents are built at elaboration with vrp_pkg::sin_q14.
module vrp_sincos_rom #(
	parameter int ANGLE_STEPS = 360
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [vrp_pkg::ANGLE_W-1:0]  angle,
	output vrp_pkg::trig_t               trig_s1
);

	localparam int DEPTH = 1 << vrp_pkg::ANGLE_W;

	vrp_pkg::trig_t rom [DEPTH];

	// codes at or above ANGLE_STEPS wrap; cosine uses the angle advanced by pi/2
	for (genvar j = 0; j < DEPTH; j++) begin : g_entry
		localparam longint K  = j % ANGLE_STEPS;
		localparam longint A  = (K * vrp_pkg::TWO_PI_Q30) / ANGLE_STEPS;
		localparam longint B0 = A + vrp_pkg::HALF_PI_Q30;
		localparam longint B  = (B0 >= vrp_pkg::TWO_PI_Q30) ? B0 - vrp_pkg::TWO_PI_Q30 : B0;
		assign rom[j] = {vrp_pkg::sin_q14(A), vrp_pkg::sin_q14(B)};
	end

	// registered read, held while the stage is stalled
	always_ff @(posedge clk) begin
		if (en)
			trig_s1 <= rom[angle];
	end

endmodule

>>> rtl/vrp_pixel_out.sv
// Output stage: screen offset, round to nearest even, saturate, output register.
// Depends on vrp_pkg and the assertion macro header.
`include "vertex_rotate_project_top_defines.svh"

module vrp_pixel_out #(
	parameter int COORD_FRAC_BITS = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s7,
	input  vrp_pkg::coord_t                     x_s7,
	input  vrp_pkg::coord_t                     y_s7,
	input  vrp_pkg::cfg_t                       cfg,
	output logic                                en_s8,
	output logic                                pix_valid,
	input  logic                                pix_stall,
	output logic signed [vrp_pkg::SCREEN_W-1:0] screen_x,
	output logic signed [vrp_pkg::SCREEN_W-1:0] screen_y
);

	localparam int OFF_W = vrp_pkg::OFFSET_W + COORD_FRAC_BITS + 1;
	localparam int SUM_W = ((OFF_W > vrp_pkg::COORD_W) ? OFF_W : vrp_pkg::COORD_W) + 1;
	localparam int Q_W   = SUM_W - COORD_FRAC_BITS;
	localparam int QR_W  = ((Q_W + 1) > (vrp_pkg::SCREEN_W + 1)) ? (Q_W + 1)
		: (vrp_pkg::SCREEN_W + 1);

	logic [SUM_W-1:0]        off_x;
	logic [SUM_W-1:0]        off_y;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;

	// fixed point to pixel: round half to even, then clamp to 16 bits
	function automatic logic signed [vrp_pkg::SCREEN_W-1:0] to_pixel(
		input logic signed [SUM_W-1:0] v
	);
		logic signed [QR_W-1:0]        q;
		logic [COORD_FRAC_BITS-1:0]    r;
		logic                          inc;
		logic signed [QR_W-1:0]        qr;
		logic [QR_W-vrp_pkg::SCREEN_W:0] top;
		q   = QR_W'(v >>> COORD_FRAC_BITS);
		r   = v[COORD_FRAC_BITS-1:0];
		inc = r[COORD_FRAC_BITS-1] && ((|r[COORD_FRAC_BITS-2:0]) || q[0]);
		qr  = q + signed'(QR_W'(inc));
		top = qr[QR_W-1:vrp_pkg::SCREEN_W-1];
		if ((&top) || !(|top))
			return qr[vrp_pkg::SCREEN_W-1:0];
		else if (qr[QR_W-1])
			return vrp_pkg::PIX_MIN;
		else
			return vrp_pkg::PIX_MAX;
	endfunction

	// frame centre offsets
	assign off_x = SUM_W'({cfg.half_width, {COORD_FRAC_BITS{1'b0}}});
	assign off_y = SUM_W'({cfg.half_height, {COORD_FRAC_BITS{1'b0}}});
	assign sum_x = signed'(off_x) + SUM_W'(x_s7);
	assign sum_y = signed'(off_y) - SUM_W'(y_s7);

	// output register frees whenever the word is taken or the slot is empty
	assign en_s8 = !pix_valid || !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pix_valid <= 1'b0;
		else if (en_s8)
			pix_valid <= valid_s7;
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			screen_x <= to_pixel(sum_x);
			screen_y <= to_pixel(sum_y);
		end
	end

	`VRP_ASSERT_IMP(a_out_from_s7, $rose(pix_valid), $past(valid_s7), "output word with no stage-7 word")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for vertex_rotate_project_top: queued vertex words in, pixel words out.
// Depends on vrp_pkg for widths, register indexes, reset values and angle constants.

module testbench;

	localparam int ANGLE_STEPS = 360;
	localparam int COORD_FRAC  = 13;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 12;
	localparam longint TIE_HALF = 64'sd1 << (COORD_FRAC - 1);

	typedef struct {
		logic signed [vrp_pkg::VTX_W-1:0]  x;
		logic signed [vrp_pkg::VTX_W-1:0]  y;
		logic signed [vrp_pkg::VTX_W-1:0]  z;
		logic        [vrp_pkg::ANGLE_W-1:0] ax;
		logic        [vrp_pkg::ANGLE_W-1:0] ay;
		logic        [vrp_pkg::ANGLE_W-1:0] az;
	} vertex_word_t;

	typedef struct {
		logic signed [vrp_pkg::SCREEN_W-1:0] sx;
		logic signed [vrp_pkg::SCREEN_W-1:0] sy;
	} pixel_word_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [vrp_pkg::CFG_ADDR_W-1:0] paddr;
	logic [vrp_pkg::CFG_DATA_W-1:0] pwdata;
	logic [vrp_pkg::CFG_DATA_W-1:0] prdata;
	logic pready;
	logic vtx_valid;
	logic vtx_stall;
	logic signed [vrp_pkg::VTX_W-1:0] vertex_x;
	logic signed [vrp_pkg::VTX_W-1:0] vertex_y;
	logic signed [vrp_pkg::VTX_W-1:0] vertex_z;
	logic [vrp_pkg::ANGLE_W-1:0] angle_x_deg;
	logic [vrp_pkg::ANGLE_W-1:0] angle_y_deg;
	logic [vrp_pkg::ANGLE_W-1:0] angle_z_deg;
	logic pix_valid;
	logic pix_stall;
	logic signed [vrp_pkg::SCREEN_W-1:0] screen_x;
	logic signed [vrp_pkg::SCREEN_W-1:0] screen_y;

	vertex_word_t vertex_q[$];
	pixel_word_t  pixel_due_q[$];
	vertex_word_t cur_vertex;
	vrp_pkg::cfg_t shadow_cfg;
	longint sin_rom[ANGLE_STEPS];
	longint cos_rom[ANGLE_STEPS];
	logic vtx_taken;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;
	int hold_ack;
	int hold_left;
	int mismatch_count;

	vertex_rotate_project_top #(
		.ANGLE_STEPS     (ANGLE_STEPS),
		.COORD_FRAC_BITS (COORD_FRAC)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.vtx_valid   (vtx_valid),
		.vtx_stall   (vtx_stall),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.vertex_z    (vertex_z),
		.angle_x_deg (angle_x_deg),
		.angle_y_deg (angle_y_deg),
		.angle_z_deg (angle_z_deg),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.screen_x    (screen_x),
		.screen_y    (screen_y)
	);

	// sine of a first-quadrant angle, Q30 in and out, eleven Taylor terms
	function automatic longint unsigned taylor_sine_q30(input longint unsigned ang);
		longint unsigned sq;
		longint unsigned term;
		longint unsigned acc;
		sq = (ang * ang) >> 30;
		term = ang;
		acc = ang;
		for (int n = 1; n <= 10; n++) begin
			term = ((term * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1)
				acc = acc - term;
			else
				acc = acc + term;
		end
		return acc;
	endfunction

	// sine in Q1.14 of an angle in [0, 2pi) given in Q30 radians
	function automatic longint rom_sine(input longint phase);
		logic flip;
		longint unsigned s;
		longint unsigned r;
		flip = 1'b0;
		if (phase >= vrp_pkg::PI_Q30) begin
			phase = phase - vrp_pkg::PI_Q30;
			flip = 1'b1;
		end
		if (phase > vrp_pkg::HALF_PI_Q30)
			phase = vrp_pkg::PI_Q30 - phase;
		if (phase < 0)
			phase = 0;
		s = taylor_sine_q30(unsigned'(phase));
		r = (s + 64'd32768) >> 16;
		if (r > 64'd16384)
			r = 64'd16384;
		return flip ? -longint'(r) : longint'(r);
	endfunction

	// sum of two Q14 products back to coordinate scale, half up
	function automatic longint half_up14(input longint p, input longint q);
		return (p + q + 64'sd8192) >>> 14;
	endfunction

	// nearest pixel, ties to even, clamped to 16 bits
	function automatic logic signed [vrp_pkg::SCREEN_W-1:0] pixel_round(input longint v);
		longint q;
		longint r;
		q = v >>> COORD_FRAC;
		r = v - (q <<< COORD_FRAC);
		if (r > TIE_HALF || (r == TIE_HALF && q[0]))
			q = q + 1;
		if (q > longint'(vrp_pkg::PIX_MAX))
			q = longint'(vrp_pkg::PIX_MAX);
		if (q < longint'(vrp_pkg::PIX_MIN))
			q = longint'(vrp_pkg::PIX_MIN);
		return q[vrp_pkg::SCREEN_W-1:0];
	endfunction

	// scale, rotate X then Y then Z, drop z, offset to screen
	function automatic pixel_word_t project_vertex(input vertex_word_t v, input vrp_pkg::cfg_t c);
		longint sc;
		longint px;
		longint py;
		longint pz;
		longint t;
		longint sa;
		longint ca;
		longint sb;
		longint cb;
		longint sg;
		longint cg;
		pixel_word_t p;
		sc = longint'(c.scale_factor);
		px = longint'(v.x) * sc;
		py = longint'(v.y) * sc;
		pz = longint'(v.z) * sc;
		sa = sin_rom[v.ax % ANGLE_STEPS];
		ca = cos_rom[v.ax % ANGLE_STEPS];
		sb = sin_rom[v.ay % ANGLE_STEPS];
		cb = cos_rom[v.ay % ANGLE_STEPS];
		sg = sin_rom[v.az % ANGLE_STEPS];
		cg = cos_rom[v.az % ANGLE_STEPS];
		t = half_up14(ca * py, -sa * pz);
		pz = half_up14(sa * py, ca * pz);
		py = t;
		t = half_up14(cb * px, sb * pz);
		pz = half_up14(-sb * px, cb * pz);
		px = t;
		t = half_up14(cg * px, -sg * py);
		py = half_up14(sg * px, cg * py);
		px = t;
		p.sx = pixel_round((longint'(c.half_width) <<< COORD_FRAC) + px);
		p.sy = pixel_round((longint'(c.half_height) <<< COORD_FRAC) - py);
		return p;
	endfunction

	// mostly full-range words; some small multiples of half a pixel to hit rounding ties
	function automatic vertex_word_t random_vertex();
		vertex_word_t v;
		if ($urandom_range(7) == 0) begin
			v.x = 16'($signed($urandom_range(0, 15)) * 4096 - 32768);
			v.y = 16'($signed($urandom_range(0, 15)) * 4096 - 32768);
			v.z = 16'($signed($urandom_range(0, 15)) * 4096 - 32768);
		end else begin
			v.x = 16'($urandom);
			v.y = 16'($urandom);
			v.z = 16'($urandom);
		end
		v.ax = 9'($urandom_range(511));
		v.ay = 9'($urandom_range(511));
		v.az = 9'($urandom_range(511));
		return v;
	endfunction

	task automatic queue_vertex(input int x, input int y, input int z,
			input int ax, input int ay, input int az);
		vertex_word_t v;
		v.x = 16'(x);
		v.y = 16'(y);
		v.z = 16'(z);
		v.ax = 9'(ax);
		v.ay = 9'(ay);
		v.az = 9'(az);
		vertex_q = {vertex_q, v};
	endtask

	// setup then access phase; pready is tied high so the access lands at once
	task automatic write_reg(input logic [vrp_pkg::REG_IDX_W-1:0] idx,
			input logic [vrp_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= vrp_pkg::CFG_ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			vrp_pkg::REG_SCALE_FACTOR: shadow_cfg.scale_factor = data[vrp_pkg::SCALE_W-1:0];
			vrp_pkg::REG_HALF_WIDTH:   shadow_cfg.half_width   = data[vrp_pkg::OFFSET_W-1:0];
			vrp_pkg::REG_HALF_HEIGHT:  shadow_cfg.half_height  = data[vrp_pkg::OFFSET_W-1:0];
			default: ;
		endcase
	endtask

	// upper data bits carry noise, the register keeps only its own width
	task automatic set_config(input int scale, input int hw, input int hh);
		logic [vrp_pkg::CFG_DATA_W-1:0] data;
		data = $urandom;
		data[vrp_pkg::SCALE_W-1:0] = vrp_pkg::SCALE_W'(scale);
		write_reg(vrp_pkg::REG_SCALE_FACTOR, data);
		data = $urandom;
		data[vrp_pkg::OFFSET_W-1:0] = vrp_pkg::OFFSET_W'(hw);
		write_reg(vrp_pkg::REG_HALF_WIDTH, data);
		data = $urandom;
		data[vrp_pkg::OFFSET_W-1:0] = vrp_pkg::OFFSET_W'(hh);
		write_reg(vrp_pkg::REG_HALF_HEIGHT, data);
	endtask

	// wait for every queued word to go in and every pixel word to come out;
	// sampled at the rising edge, where the driver's outputs are settled
	task automatic wait_drained();
		do
			@(posedge clk);
		while (vertex_q.size() != 0 || vtx_valid || pixel_due_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// vertex driver: new word only once the previous one is taken
	always @(negedge clk) begin
		if (!arst_n) begin
			vtx_valid <= 1'b0;
		end else if (!vtx_valid || vtx_taken) begin
			vtx_taken = 1'b0;
			if (vertex_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				cur_vertex = vertex_q.pop_front();
				vertex_x <= cur_vertex.x;
				vertex_y <= cur_vertex.y;
				vertex_z <= cur_vertex.z;
				angle_x_deg <= cur_vertex.ax;
				angle_y_deg <= cur_vertex.ay;
				angle_z_deg <= cur_vertex.az;
				vtx_valid <= 1'b1;
			end else begin
				vtx_valid <= 1'b0;
			end
		end
	end

	// pixel receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pix_stall <= 1'b1;
		end else if (hold_req != hold_ack) begin
			hold_ack = hold_req;
			hold_left = HOLD_CYCLES - 1;
			pix_stall <= 1'b1;
		end else begin
			pix_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// monitor: check outgoing pixel words, then predict for the incoming vertex
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall) begin
			if (pixel_due_q.size() == 0) begin
				$error("pixel word with nothing expected: screen_x %0d screen_y %0d",
					screen_x, screen_y);
				mismatch_count = mismatch_count + 1;
			end else begin
				if (screen_x !== pixel_due_q[0].sx) begin
					$error("screen_x: expected %0d, got %0d", pixel_due_q[0].sx, screen_x);
					mismatch_count = mismatch_count + 1;
				end
				if (screen_y !== pixel_due_q[0].sy) begin
					$error("screen_y: expected %0d, got %0d", pixel_due_q[0].sy, screen_y);
					mismatch_count = mismatch_count + 1;
				end
				void'(pixel_due_q.pop_front());
			end
		end
		if (arst_n && vtx_valid && !vtx_stall) begin
			pixel_due_q = {pixel_due_q, project_vertex(cur_vertex, shadow_cfg)};
			vtx_taken = 1'b1;
		end
	end

	// watchdog on cycles with no word moving on either side
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((vtx_valid && !vtx_stall) || (pix_valid && !pix_stall))
				quiet = 0;
			else
				quiet = quiet + 1;
		end
		$display("vertex_rotate_project_top verification failed");
		$finish;
	end

	initial begin
		longint a;
		longint b;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		vtx_valid = 1'b0;
		vertex_x = '0;
		vertex_y = '0;
		vertex_z = '0;
		angle_x_deg = '0;
		angle_y_deg = '0;
		angle_z_deg = '0;
		pix_stall = 1'b0;
		vtx_taken = 1'b0;
		tx_idle_pct = 24;
		rx_idle_pct = 24;
		hold_req = 0;
		hold_ack = 0;
		hold_left = 0;
		mismatch_count = 0;
		shadow_cfg.scale_factor = vrp_pkg::SCALE_RESET;
		shadow_cfg.half_width = vrp_pkg::HALF_W_RESET;
		shadow_cfg.half_height = vrp_pkg::HALF_H_RESET;

		// sine and cosine tables, cosine as sine advanced a quarter turn
		for (int k = 0; k < ANGLE_STEPS; k++) begin
			a = (longint'(k) * vrp_pkg::TWO_PI_Q30) / ANGLE_STEPS;
			b = a + vrp_pkg::HALF_PI_Q30;
			if (b >= vrp_pkg::TWO_PI_Q30)
				b = b - vrp_pkg::TWO_PI_Q30;
			sin_rom[k] = rom_sine(a);
			cos_rom[k] = rom_sine(b);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset config: field extremes, quarter turns, top angle codes and wrapped codes
		queue_vertex(0, 0, 0, 0, 0, 0);
		queue_vertex(32767, 32767, 32767, 0, 0, 0);
		queue_vertex(-32768, -32768, -32768, 0, 0, 0);
		queue_vertex(8192, 0, 0, 90, 0, 0);
		queue_vertex(0, 8192, 0, 90, 0, 0);
		queue_vertex(0, 8192, 0, 0, 0, 90);
		queue_vertex(8192, 0, 0, 0, 180, 0);
		queue_vertex(0, 0, 8192, 0, 270, 0);
		queue_vertex(8192, 8192, 8192, 359, 359, 359);
		queue_vertex(8192, -8192, 4096, 360, 360, 360);
		queue_vertex(1000, -2000, 3000, 511, 511, 511);
		queue_vertex(0, 0, 8192, 45, 45, 45);
		wait_drained();

		// unit scale, zero offsets: exact half-pixel ties go to even
		set_config(1, 0, 0);
		queue_vertex(4096, 0, 0, 0, 0, 0);
		queue_vertex(12288, 0, 0, 0, 0, 0);
		queue_vertex(-4096, 0, 0, 0, 0, 0);
		queue_vertex(0, 4096, 0, 0, 0, 0);
		queue_vertex(0, -12288, 0, 0, 0, 0);
		queue_vertex(4097, 4095, 0, 0, 0, 0);
		wait_drained();

		// top scale and offsets with extreme coordinates
		set_config(1023, 4095, 4095);
		queue_vertex(32767, 32767, 32767, 0, 0, 0);
		queue_vertex(-32768, -32768, -32768, 0, 0, 0);
		queue_vertex(32767, -32768, 32767, 45, 45, 45);
		queue_vertex(-32768, 32767, -32768, 135, 225, 315);
		queue_vertex(32767, 0, 0, 0, 0, 180);
		wait_drained();

		// random phases over several settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				3: set_config(0, 0, 4095);
				4: set_config(1023, 4095, 0);
				default: set_config($urandom_range(1023), $urandom_range(4095),
					$urandom_range(4095));
			endcase
			tx_idle_pct = (phase == 1 || phase == 2) ? 0 : 24;
			rx_idle_pct = (phase == 1) ? 0 : 24;
			// long receiver hold-off while the sender keeps offering
			if (phase == 2)
				hold_req = hold_req + 1;
			for (int i = 0; i < 150; i++)
				vertex_q = {vertex_q, random_vertex()};
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("vertex_rotate_project_top verification clean");
		else
			$display("vertex_rotate_project_top verification failed");
		$finish;
	end

endmodule
